// ===== design/pkb_pkg.sv =====
// Package: shared constants and codes for the pixel key/blend write stage.
`timescale 1ns / 1ps
`default_nettype none

package pkb_pkg;

  // Framebuffer address arithmetic.
  localparam int unsigned ADDR_BITS = 24;
  localparam int unsigned WADDR_W   = 24;
  localparam logic [WADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= WADDR_W) ? {WADDR_W{1'b1}}
                           : WADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam int unsigned COORD_W = 13;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned GALPHA_W = 9;
  localparam int unsigned SCALE_W = 17;   // global alpha times source alpha
  localparam int unsigned PROD_W  = 24;   // scale times channel difference

  localparam logic [GALPHA_W-1:0] GALPHA_ONE = GALPHA_W'(256);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_DRAW_MODE     = 3'd2,
    CFG_KEY_COLOR     = 3'd3,
    CFG_GLOBAL_ALPHA  = 3'd4
  } cfg_idx_e;

  localparam logic [DIM_W-1:0]    RST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0]    RST_HEIGHT = DIM_W'(480);
  localparam logic [1:0]          RST_MODE   = 2'd0;
  localparam logic [RGB_W-1:0]    RST_KEY    = 24'hFFFFFF;
  localparam logic [GALPHA_W-1:0] RST_GALPHA = GALPHA_W'(256);

  // draw_mode bits
  localparam int unsigned MODE_KEY_BIT   = 0;
  localparam int unsigned MODE_BLEND_BIT = 1;

  typedef enum logic [1:0] {
    SKIP_NONE = 2'd0,
    SKIP_CLIP = 2'd1,
    SKIP_KEY  = 2'd2
  } skip_e;

endpackage

`default_nettype wire

// ===== design/pkb_if.sv =====
// Interfaces: pixel input channel, write command channel, configuration channel.
`timescale 1ns / 1ps
`default_nettype none

interface pkb_pix_if;
  import pkb_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  dest_x;
  logic signed [COORD_W-1:0]  dest_y;
  logic        [COLOR_W-1:0]  src_color;
  logic        [COLOR_W-1:0]  dst_color;

  modport source (output valid, dest_x, dest_y, src_color, dst_color, input ready);
  modport sink   (input valid, dest_x, dest_y, src_color, dst_color, output ready);
endinterface

interface pkb_wr_if;
  import pkb_pkg::*;
  logic                valid;
  logic                ready;
  logic                write_enable;
  logic [WADDR_W-1:0]  write_address;
  logic [COLOR_W-1:0]  write_color;
  logic [1:0]          skip_reason;

  modport source (output valid, write_enable, write_address, write_color, skip_reason,
                  input ready);
  modport sink   (input valid, write_enable, write_address, write_color, skip_reason,
                  output ready);
endinterface

interface pkb_cfg_if;
  import pkb_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/pkb_blend_lane.sv =====
// One color channel of the alpha blend: product stage and divide-by-65280 result.
`timescale 1ns / 1ps
`default_nettype none

module pkb_blend_lane
  import pkb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,     // stage 2 load
  input  wire logic [7:0]         s_i,
  input  wire logic [7:0]         d_i,
  input  wire logic [SCALE_W-1:0] scale_i,
  output logic      [7:0]         chan_o
);

  logic              ge_d, ge_q;
  logic [7:0]        diff;
  logic [7:0]        d_q;
  logic [PROD_W-1:0] p_d, p_q;
  logic [15:0]       t;
  logic [16:0]       q_sum;
  logic [7:0]        q;

  assign ge_d = (s_i >= d_i);
  assign diff = ge_d ? (s_i - d_i) : (d_i - s_i);
  assign p_d  = PROD_W'(scale_i) * PROD_W'(diff);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ge_q <= ge_d;
      d_q  <= d_i;
      p_q  <= p_d;
    end
  end

  // p / 65280 = (p >> 8) / 255; the /255 is exact for t below 65535
  assign t      = p_q[PROD_W-1:8];
  assign q_sum  = 17'(t) + 17'd1 + 17'(t[15:8]);
  assign q      = q_sum[15:8];
  assign chan_o = ge_q ? (d_q + q) : (d_q - q);

endmodule

`default_nettype wire

// ===== design/pixel_key_blend_writer_top.sv =====
// Top level: pixel key/blend write stage, three-stage pipeline with config registers.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | payload                                              | transfer when
//  --------+-----+------------------------------------------------------+------------------
//  pix_i   | in  | dest_x, dest_y, src_color, dst_color                 | valid & ready
//  wr_o    | out | write_enable, write_address, write_color, skip_reason| valid & ready
//  cfg_i   | in  | index (register number), data                        | valid & ready
//
//  Three register stages: a result passes stage 1, stage 2 and the output register
//  before it shows on wr_o; one pixel is taken every cycle unless a wr_o stall has filled all three.
//  The multipliers (y*width, galpha*srcA, scale*diff) set the stage split.
//  rst_ni clears the stage valids and loads the register reset values. A stall
//  on wr_o fills the pipeline stage by stage; pix_i.ready drops only when all
//  three stages hold a pixel. cfg_i is always ready.

module pixel_key_blend_writer_top
  import pkb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pkb_pix_if.sink    pix_i,
  pkb_wr_if.source   wr_o,
  pkb_cfg_if.sink    cfg_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]    width_q, height_q;
  logic [1:0]          mode_q;
  logic [RGB_W-1:0]    key_q;
  logic [GALPHA_W-1:0] galpha_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      mode_q   <= RST_MODE;
      key_q    <= RST_KEY;
      galpha_q <= RST_GALPHA;
    end else if (cfg_i.valid) begin
      // out-of-range indexes fall through and are dropped
      unique case (cfg_i.index)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_i.data[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: height_q <= cfg_i.data[DIM_W-1:0];
        CFG_DRAW_MODE:     mode_q   <= cfg_i.data[1:0];
        CFG_KEY_COLOR:     key_q    <= cfg_i.data[RGB_W-1:0];
        CFG_GLOBAL_ALPHA:  galpha_q <= cfg_i.data[GALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or drains forward
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic adv1, adv2, adv3;

  assign adv3        = !out_v_q || wr_o.ready;
  assign adv2        = !s2_v_q  || adv3;
  assign adv1        = !s1_v_q  || adv2;
  assign pix_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q  <= pix_i.valid;
      if (adv2) s2_v_q  <= s1_v_q;
      if (adv3) out_v_q <= s2_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: key test, clip test, row product, alpha scale
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0]  x_u, y_u;
  logic                key_hit, clipped;
  logic [GALPHA_W-1:0] galpha_sat;
  skip_e               s1_skip_d, s1_skip_q;
  logic                s1_blend_q;
  logic [11:0]         s1_x_q;
  logic [24:0]         s1_prod_d, s1_prod_q;
  logic [SCALE_W-1:0]  s1_scale_d, s1_scale_q;
  logic [COLOR_W-1:0]  s1_src_q, s1_dst_q;

  assign x_u = pix_i.dest_x;
  assign y_u = pix_i.dest_y;

  assign key_hit = mode_q[MODE_KEY_BIT] && (pix_i.src_color[RGB_W-1:0] == key_q);
  assign clipped = x_u[COORD_W-1] || y_u[COORD_W-1] ||
                   (x_u >= width_q) || (y_u >= height_q);

  // key check wins over clipping
  always_comb begin
    priority if (key_hit) s1_skip_d = SKIP_KEY;
    else if (clipped)     s1_skip_d = SKIP_CLIP;
    else                  s1_skip_d = SKIP_NONE;
  end

  assign galpha_sat = (galpha_q > GALPHA_ONE) ? GALPHA_ONE : galpha_q;
  assign s1_scale_d = SCALE_W'(galpha_sat) * SCALE_W'(pix_i.src_color[31:24]);
  assign s1_prod_d  = 25'(y_u[11:0]) * 25'(width_q);

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_skip_q  <= s1_skip_d;
      s1_blend_q <= mode_q[MODE_BLEND_BIT];
      s1_x_q     <= x_u[11:0];
      s1_prod_q  <= s1_prod_d;
      s1_scale_q <= s1_scale_d;
      s1_src_q   <= pix_i.src_color;
      s1_dst_q   <= pix_i.dst_color;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: address add; lanes register scale*|src-dst|
  // ---------------------------------------------------------------------------
  skip_e              s2_skip_q;
  logic               s2_blend_q;
  logic [25:0]        s2_addr_d, s2_addr_q;
  logic [COLOR_W-1:0] s2_src_q;
  logic [7:0]         s2_dalpha_q;
  logic [7:0]         chan_r, chan_g, chan_b;

  assign s2_addr_d = 26'(s1_prod_q) + 26'(s1_x_q);

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_skip_q   <= s1_skip_q;
      s2_blend_q  <= s1_blend_q;
      s2_addr_q   <= s2_addr_d;
      s2_src_q    <= s1_src_q;
      s2_dalpha_q <= s1_dst_q[31:24];
    end
  end

  pkb_blend_lane u_lane_r (
    .clk_i   (clk_i),
    .en_i    (adv2),
    .s_i     (s1_src_q[23:16]),
    .d_i     (s1_dst_q[23:16]),
    .scale_i (s1_scale_q),
    .chan_o  (chan_r)
  );

  pkb_blend_lane u_lane_g (
    .clk_i   (clk_i),
    .en_i    (adv2),
    .s_i     (s1_src_q[15:8]),
    .d_i     (s1_dst_q[15:8]),
    .scale_i (s1_scale_q),
    .chan_o  (chan_g)
  );

  pkb_blend_lane u_lane_b (
    .clk_i   (clk_i),
    .en_i    (adv2),
    .s_i     (s1_src_q[7:0]),
    .d_i     (s1_dst_q[7:0]),
    .scale_i (s1_scale_q),
    .chan_o  (chan_b)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: divide finish, color select, output register
  // ---------------------------------------------------------------------------
  logic               we_d, we_q;
  logic [WADDR_W-1:0] addr_d, addr_q;
  logic [COLOR_W-1:0] color_d, color_q;
  skip_e              skip_q;

  always_comb begin
    we_d    = (s2_skip_q == SKIP_NONE);
    addr_d  = '0;
    color_d = '0;
    if (we_d) begin
      addr_d  = s2_addr_q[WADDR_W-1:0] & ADDR_MASK;
      color_d = s2_blend_q ? {s2_dalpha_q, chan_r, chan_g, chan_b} : s2_src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      we_q    <= we_d;
      addr_q  <= addr_d;
      color_q <= color_d;
      skip_q  <= s2_skip_q;
    end
  end

  assign wr_o.valid         = out_v_q;
  assign wr_o.write_enable  = we_q;
  assign wr_o.write_address = addr_q;
  assign wr_o.write_color   = color_q;
  assign wr_o.skip_reason   = skip_q;

endmodule

`default_nettype wire

// ===== design/pkb_checker.sv =====
// Port checker for the pixel key/blend write stage, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pkb_checker
  import pkb_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               write_enable,
  input wire logic [WADDR_W-1:0] write_address,
  input wire logic [COLOR_W-1:0] write_color,
  input wire logic [1:0]         skip_reason
);

  // write_enable and a zero skip code go together
  a_we_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (write_enable == (skip_reason == SKIP_NONE)))
    else $error("write_enable disagrees with skip_reason");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !write_enable) |-> (write_address == '0 && write_color == '0))
    else $error("skipped pixel carries address or color");

  a_skip_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (skip_reason == SKIP_NONE || skip_reason == SKIP_CLIP ||
                   skip_reason == SKIP_KEY))
    else $error("unused skip code");

  // input backpressure only comes from a stalled output
  a_bp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(write_color) &&
                                   $stable(write_address) && $stable(skip_reason)))
    else $error("stalled result changed");

endmodule

bind pixel_key_blend_writer_top pkb_checker u_pkb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready      (pix_i.ready),
  .out_valid     (wr_o.valid),
  .out_ready     (wr_o.ready),
  .write_enable  (wr_o.write_enable),
  .write_address (wr_o.write_address),
  .write_color   (wr_o.write_color),
  .skip_reason   (wr_o.skip_reason)
);

`default_nettype wire
